/* hdl/homogeneous_point_transform_top_defines.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_TOP_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HPT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpt assertion failed");

// Next-cycle implication, disabled during reset.
`define HPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpt assertion failed");

`endif

/* hdl/hpt_pkg.sv */
`default_nettype none
package hpt_pkg;

  localparam int COORD_W = 32;
  // Exact sum of three 64-bit products and one shifted coefficient
  localparam int SUM_W   = 66;
  localparam int MAC_LAT = 3;
  localparam int DIV_LAT = COORD_W + 3;
  localparam int PIPE_LAT = MAC_LAT + DIV_LAT;

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic signed [COORD_W-1:0] coef_t;
  typedef coef_t [3:0][3:0] matrix_t;   // [row][col]
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    logic signed [COORD_W-1:0] result_z;
    logic                      divide_fault;
  } result_t;

endpackage
`default_nettype wire

/* hdl/homogeneous_point_transform_top.sv */
// Channel   | Handshake                     | Payload
// request   | start / busy                  | in_point (point_x, point_y, point_z)
// result    | out_valid (one-cycle strobe)  | out_result (result_x..z, divide_fault)
// config    | psel, penable, pwrite, pready | paddr, pwdata, prdata (64-bit)
//
// One request per cycle; busy is always low.
// The multiply-add tree feeds the divider, whose 32 restoring stages (one
// quotient bit each) set the pipeline depth.
// rst_n is synchronous; it clears the valid bits and loads the identity matrix.
// The receiver cannot stall, so nothing is ever held back.
`default_nettype none
`include "homogeneous_point_transform_top_defines.svh"
module homogeneous_point_transform_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire hpt_pkg::point_t    in_point,
  output logic                    out_valid,
  output hpt_pkg::result_t        out_result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready
);
  import hpt_pkg::*;

  matrix_t matrix;
  logic    mac_vld;
  sum_t    sums [0:3];
  logic    lane_vld  [0:2];
  coef_t   lane_crd  [0:2];
  logic    lane_zero [0:2];

  assign busy = 1'b0;

  hpt_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .matrix(matrix)
  );

  hpt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk, .rst_n,
    .vld_i(start && !busy),
    .point_i(in_point),
    .matrix_i(matrix),
    .vld_o(mac_vld),
    .sum_o(sums)
  );

  // One divider lane per coordinate, all sharing the w sum
  for (genvar i = 0; i < 3; i++) begin : g_lane
    hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk, .rst_n,
      .vld_i(mac_vld),
      .num_i(sums[i]),
      .den_i(sums[3]),
      .vld_o(lane_vld[i]),
      .coord_o(lane_crd[i]),
      .zero_o(lane_zero[i])
    );
  end

  assign out_valid               = lane_vld[0];
  assign out_result.result_x     = lane_crd[0];
  assign out_result.result_y     = lane_crd[1];
  assign out_result.result_z     = lane_crd[2];
  assign out_result.divide_fault = lane_zero[0];

  `HPT_ASSERT_IMPL(a_out_from_req, out_valid, $past(start && !busy, PIPE_LAT))
  `HPT_ASSERT_IMPL(a_fault_zero, out_valid && out_result.divide_fault, (out_result.result_x == '0) && (out_result.result_y == '0) && (out_result.result_z == '0))
  `HPT_ASSERT_IMPL(a_lanes_agree, lane_vld[0], lane_vld[1] && lane_vld[2] && (lane_zero[1] == lane_zero[0]) && (lane_zero[2] == lane_zero[0]))
  `HPT_ASSERT_NEXT(a_req_flows, mac_vld, g_lane[0].u_div.a_vld_r)

endmodule
`default_nettype wire

/* hdl/hpt_cfg_regs.sv */
`default_nettype none
module hpt_cfg_regs #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [5:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic      [63:0]   prdata,
  output logic               pready,
  output hpt_pkg::matrix_t   matrix
);
  import hpt_pkg::*;

  localparam coef_t ONE = COORD_W'(64'd1 << FRAC_BITS);

  matrix_t    matrix_r;
  logic [1:0] row;
  logic       upper;

  assign row    = paddr[5:4];
  assign upper  = paddr[3];
  assign pready = 1'b1;
  assign matrix = matrix_r;

  // Return the addressed pair of coefficients
  always_comb begin
    if (upper) begin
      prdata = {matrix_r[row][3], matrix_r[row][2]};
    end else begin
      prdata = {matrix_r[row][1], matrix_r[row][0]};
    end
  end

  // Write on the access cycle; reset to identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          matrix_r[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (psel && penable && pwrite) begin
      if (upper) begin
        matrix_r[row][2] <= pwdata[31:0];
        matrix_r[row][3] <= pwdata[63:32];
      end else begin
        matrix_r[row][0] <= pwdata[31:0];
        matrix_r[row][1] <= pwdata[63:32];
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/hpt_mac.sv */
`default_nettype none
module hpt_mac #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_i,
  input  wire hpt_pkg::point_t   point_i,
  input  wire hpt_pkg::matrix_t  matrix_i,
  output logic                   vld_o,
  output hpt_pkg::sum_t          sum_o [0:3]
);
  import hpt_pkg::*;

  coef_t                   pt [0:2];
  logic signed [63:0]      prod_nxt [0:3][0:2];
  logic signed [63:0]      prod_r   [0:3][0:2];
  sum_t                    tr_nxt   [0:3];
  sum_t                    tr_r     [0:3];
  sum_t                    pa_r     [0:3];
  sum_t                    pb_r     [0:3];
  sum_t                    sum_r    [0:3];
  logic [MAC_LAT-1:0]      vld_r;

  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  // Products and translation terms, one column per output
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_nxt[c][r] = pt[r] * matrix_i[r][c];
      end
      tr_nxt[c] = SUM_W'(matrix_i[3][c]) <<< FRAC_BITS;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[MAC_LAT-2:0], vld_i};
    end
  end

  // Multiply, add pairs, then final add
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[c][r] <= prod_nxt[c][r];
      end
      tr_r[c]  <= tr_nxt[c];
      pa_r[c]  <= SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1]);
      pb_r[c]  <= SUM_W'(prod_r[c][2]) + tr_r[c];
      sum_r[c] <= pa_r[c] + pb_r[c];
    end
  end

  assign vld_o = vld_r[MAC_LAT-1];
  assign sum_o = sum_r;
endmodule
`default_nettype wire

/* hdl/hpt_div.sv */
`default_nettype none
module hpt_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           vld_i,
  input  wire hpt_pkg::sum_t  num_i,
  input  wire hpt_pkg::sum_t  den_i,
  output logic                vld_o,
  output hpt_pkg::coef_t      coord_o,
  output logic                zero_o
);
  import hpt_pkg::*;

  localparam int NW = SUM_W + FRAC_BITS;

  // Sign/magnitude stage
  logic             a_vld_r;
  logic [SUM_W-1:0] a_nmag_r;
  logic [SUM_W-1:0] a_dmag_r;
  logic             a_neg_r;
  logic             a_zero_r;

  logic [NW-1:0]    nsh;
  logic [SUM_W-1:0] nhi;
  logic             ovf;

  // Quotient stages, index 0 is the overflow-check output
  logic [COORD_W:0] vld_r;
  logic [SUM_W-1:0] rem_r  [0:COORD_W];
  logic [COORD_W-1:0] lo_r [0:COORD_W];
  logic [COORD_W-1:0] q_r  [0:COORD_W];
  logic [SUM_W-1:0] dmag_r [0:COORD_W];
  logic             neg_r  [0:COORD_W];
  logic             zero_r [0:COORD_W];
  logic             ovf_r  [0:COORD_W];

  logic [SUM_W+1:0] trial [0:COORD_W-1];
  logic             take  [0:COORD_W-1];

  logic             out_vld_r;
  coef_t            coord_r;
  logic             zero_out_r;
  coef_t            coord_nxt;

  // Scale numerator and test for a quotient of 2^32 or more
  always_comb begin
    nsh = {a_nmag_r, {FRAC_BITS{1'b0}}};
    nhi = SUM_W'(nsh[NW-1:COORD_W]);
    ovf = (nhi >= a_dmag_r);
  end

  // One restoring step per stage
  always_comb begin
    for (int k = 0; k < COORD_W; k++) begin
      trial[k] = {1'b0, rem_r[k], lo_r[k][COORD_W-1]} - {2'b0, dmag_r[k]};
      take[k]  = !trial[k][SUM_W+1];
    end
  end

  // Apply sign, saturate, force zero on a zero divisor
  always_comb begin
    if (zero_r[COORD_W]) begin
      coord_nxt = '0;
    end else if (neg_r[COORD_W]) begin
      if (ovf_r[COORD_W] || (q_r[COORD_W] > SAT_NEG)) begin
        coord_nxt = SAT_NEG;
      end else begin
        coord_nxt = -q_r[COORD_W];
      end
    end else begin
      if (ovf_r[COORD_W] || q_r[COORD_W][COORD_W-1]) begin
        coord_nxt = SAT_POS;
      end else begin
        coord_nxt = q_r[COORD_W];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      a_vld_r   <= vld_i;
      vld_r     <= {vld_r[COORD_W-1:0], a_vld_r};
      out_vld_r <= vld_r[COORD_W];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    a_nmag_r <= num_i[SUM_W-1] ? SUM_W'(-num_i) : SUM_W'(num_i);
    a_dmag_r <= den_i[SUM_W-1] ? SUM_W'(-den_i) : SUM_W'(den_i);
    a_neg_r  <= num_i[SUM_W-1] ^ den_i[SUM_W-1];
    a_zero_r <= (den_i == '0);

    rem_r[0]  <= ovf ? '0 : nhi;
    lo_r[0]   <= nsh[COORD_W-1:0];
    q_r[0]    <= '0;
    dmag_r[0] <= a_dmag_r;
    neg_r[0]  <= a_neg_r;
    zero_r[0] <= a_zero_r;
    ovf_r[0]  <= ovf;

    for (int k = 0; k < COORD_W; k++) begin
      rem_r[k+1]  <= take[k] ? trial[k][SUM_W-1:0] : {rem_r[k][SUM_W-2:0], lo_r[k][COORD_W-1]};
      lo_r[k+1]   <= {lo_r[k][COORD_W-2:0], 1'b0};
      q_r[k+1]    <= {q_r[k][COORD_W-2:0], take[k]};
      dmag_r[k+1] <= dmag_r[k];
      neg_r[k+1]  <= neg_r[k];
      zero_r[k+1] <= zero_r[k];
      ovf_r[k+1]  <= ovf_r[k];
    end

    coord_r    <= coord_nxt;
    zero_out_r <= zero_r[COORD_W];
  end

  assign vld_o   = out_vld_r;
  assign coord_o = coord_r;
  assign zero_o  = zero_out_r;
endmodule
`default_nettype wire
